// File: rtl/sqc_pkg.sv
// ----------------------------------------------------------------------------
// sqc_pkg
// shared widths, register indexes and pipeline payload types for the sprite
// quad clip vertex generator
// ----------------------------------------------------------------------------
package sqc_pkg;

  localparam int COORD_W    = 24;
  localparam int TEX_W      = 16;
  localparam int COLOR_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int FRAC_W     = FRAC_BITS + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_STAGES = 5;
  localparam int DIV_STEP   = FRAC_BITS / (DIV_STAGES - 1);

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_EN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_EN    = 3'd5;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W:0]   ext_t;
  typedef logic signed [TEX_W-1:0]   tex_t;

  // per-sprite data that rides alongside the dividers and texture unit
  typedef struct packed {
    coord_t              pz;
    ext_t                xs0;
    ext_t                xs1;
    ext_t                ys0;
    ext_t                ys1;
    tex_t                ou;
    tex_t                ov;
    tex_t                xu;
    tex_t                xv;
    tex_t                yu;
    tex_t                yv;
    logic [COLOR_W-1:0]  col;
    logic                cull;
    logic                clip;
  } side_t;

  // a finished sprite handed to the vertex serialiser
  typedef struct packed {
    coord_t                  pz;
    ext_t                    xs0;
    ext_t                    xs1;
    ext_t                    ys0;
    ext_t                    ys1;
    logic [3:0][TEX_W-1:0]   tu;
    logic [3:0][TEX_W-1:0]   tv;
    logic [COLOR_W-1:0]      col;
    logic                    cull;
  } quad_t;

endpackage

// File: rtl/sqc_div.sv
// ----------------------------------------------------------------------------
// sqc_div
// pipelined restoring divider: frac = floor(num * 2^16 / den), limited to 0..1
// ----------------------------------------------------------------------------
module sqc_div (
  input  logic                               clk,
  input  logic [sqc_pkg::DIV_STAGES-1:0]     en,
  input  sqc_pkg::ext_t                      num,
  input  sqc_pkg::coord_t                    den,
  output logic [sqc_pkg::FRAC_W-1:0]         frac
);
  import sqc_pkg::*;

  localparam int RW = COORD_W - 1;

  logic [RW-1:0]        r    [DIV_STAGES];
  logic [RW-1:0]        d    [DIV_STAGES];
  logic [FRAC_BITS-1:0] q    [DIV_STAGES];
  logic                 zero [DIV_STAGES];
  logic                 one  [DIV_STAGES];
  logic [RW-1:0]        r_next [DIV_STAGES];
  logic [FRAC_BITS-1:0] q_next [DIV_STAGES];

  always_comb begin
    logic [RW-1:0]        rr;
    logic [FRAC_BITS-1:0] qq;
    logic [RW:0]          t;
    r_next[0] = '0;
    q_next[0] = '0;
    for (int i = 1; i < DIV_STAGES; i++) begin
      rr = r[i-1];
      qq = q[i-1];
      for (int b = 0; b < DIV_STEP; b++) begin
        t = {rr, 1'b0};
        if (t >= {1'b0, d[i-1]}) begin
          rr = RW'(t - {1'b0, d[i-1]});
          qq = {qq[FRAC_BITS-2:0], 1'b1};
        end else begin
          rr = t[RW-1:0];
          qq = {qq[FRAC_BITS-2:0], 1'b0};
        end
      end
      r_next[i] = rr;
      q_next[i] = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      zero[0] <= (num <= 0) || (den <= 0);
      one[0]  <= num >= ext_t'(den);
      r[0]    <= num[RW-1:0];
      d[0]    <= den[RW-1:0];
      q[0]    <= '0;
    end
    for (int i = 1; i < DIV_STAGES; i++) begin
      if (en[i]) begin
        zero[i] <= zero[i-1];
        one[i]  <= one[i-1];
        r[i]    <= r_next[i];
        d[i]    <= d[i-1];
        q[i]    <= q_next[i];
      end
    end
  end

  assign frac = zero[DIV_STAGES-1] ? '0 :
                one[DIV_STAGES-1]  ? FRAC_ONE : {1'b0, q[DIV_STAGES-1]};

endmodule

// File: rtl/sqc_tex.sv
// ----------------------------------------------------------------------------
// sqc_tex
// texture coordinates of the four corners: multiply stage then sum, round
// and saturate stage
// ----------------------------------------------------------------------------
module sqc_tex (
  input  logic                                 clk,
  input  logic                                 en_mul,
  input  logic                                 en_sum,
  input  sqc_pkg::tex_t                        ou,
  input  sqc_pkg::tex_t                        ov,
  input  sqc_pkg::tex_t                        xu,
  input  sqc_pkg::tex_t                        xv,
  input  sqc_pkg::tex_t                        yu,
  input  sqc_pkg::tex_t                        yv,
  input  logic [sqc_pkg::FRAC_W-1:0]           fx0,
  input  logic [sqc_pkg::FRAC_W-1:0]           fx1,
  input  logic [sqc_pkg::FRAC_W-1:0]           fy0,
  input  logic [sqc_pkg::FRAC_W-1:0]           fy1,
  output logic [3:0][sqc_pkg::TEX_W-1:0]       tu,
  output logic [3:0][sqc_pkg::TEX_W-1:0]       tv
);
  import sqc_pkg::*;

  localparam int PW = TEX_W + FRAC_W + 1;
  localparam int SW = PW + 2;
  localparam int QW = SW - FRAC_BITS;

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef logic signed [QW-1:0] quot_t;

  prod_t pxu [2];
  prod_t pxv [2];
  prod_t pyu [2];
  prod_t pyv [2];
  tex_t  m_ou;
  tex_t  m_ov;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      pxu[0] <= PW'(xu * $signed({1'b0, fx0}));
      pxu[1] <= PW'(xu * $signed({1'b0, fx1}));
      pxv[0] <= PW'(xv * $signed({1'b0, fx0}));
      pxv[1] <= PW'(xv * $signed({1'b0, fx1}));
      pyu[0] <= PW'(yu * $signed({1'b0, fy0}));
      pyu[1] <= PW'(yu * $signed({1'b0, fy1}));
      pyv[0] <= PW'(yv * $signed({1'b0, fy0}));
      pyv[1] <= PW'(yv * $signed({1'b0, fy1}));
      m_ou   <= ou;
      m_ov   <= ov;
    end
  end

  function automatic logic [TEX_W-1:0] tex_round(tex_t o, prod_t a, prod_t b);
    sum_t  s;
    quot_t qv;
    s  = (sum_t'(o) <<< FRAC_BITS) + sum_t'(a) + sum_t'(b)
         + (sum_t'(1) <<< (FRAC_BITS - 1));
    qv = QW'(s >>> FRAC_BITS);
    if (qv > quot_t'({1'b0, {(TEX_W-1){1'b1}}}))
      tex_round = {1'b0, {(TEX_W-1){1'b1}}};
    else if (qv < quot_t'($signed({1'b1, {(TEX_W-1){1'b0}}})))
      tex_round = {1'b1, {(TEX_W-1){1'b0}}};
    else
      tex_round = qv[TEX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en_sum) begin
      for (int k = 0; k < 4; k++) begin
        tu[k] <= tex_round(m_ou, pxu[k % 2], pyu[k / 2]);
        tv[k] <= tex_round(m_ov, pxv[k % 2], pyv[k / 2]);
      end
    end
  end

endmodule

// File: rtl/sqc_out.sv
// ----------------------------------------------------------------------------
// sqc_out
// vertex serialiser: holds one sprite and issues its corners one per
// transaction, or a single culled transaction
// ----------------------------------------------------------------------------
module sqc_out (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sqc_pkg::quad_t                 quad,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [sqc_pkg::COORD_W-1:0] vert_x,
  output logic signed [sqc_pkg::COORD_W-1:0] vert_y,
  output logic signed [sqc_pkg::COORD_W-1:0] vert_z,
  output logic signed [sqc_pkg::TEX_W-1:0]   vert_u,
  output logic signed [sqc_pkg::TEX_W-1:0]   vert_v,
  output logic [sqc_pkg::COLOR_W-1:0]        vert_color,
  output logic [1:0]                         corner,
  output logic                               culled,
  output logic                               last
);
  import sqc_pkg::*;

  logic  busy;
  logic  [1:0] cnt;
  quad_t q;
  logic  last_beat;

  function automatic coord_t sat_c(ext_t v);
    if (v > ext_t'({1'b0, {(COORD_W-1){1'b1}}}))
      sat_c = {1'b0, {(COORD_W-1){1'b1}}};
    else if (v < ext_t'($signed({1'b1, {(COORD_W-1){1'b0}}})))
      sat_c = {1'b1, {(COORD_W-1){1'b0}}};
    else
      sat_c = v[COORD_W-1:0];
  endfunction

  assign last_beat = q.cull || (cnt == 2'd3);
  assign in_ready  = !busy || (out_ready && last_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (in_ready) begin
      busy <= in_valid;
      cnt  <= '0;
    end else if (out_ready) begin
      cnt  <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      q <= quad;
    end
  end

  assign out_valid  = busy;
  assign vert_x     = q.cull ? '0 : sat_c(cnt[0] ? q.xs1 : q.xs0);
  assign vert_y     = q.cull ? '0 : sat_c(cnt[1] ? q.ys1 : q.ys0);
  assign vert_z     = q.cull ? '0 : q.pz;
  assign vert_u     = q.cull ? '0 : q.tu[cnt];
  assign vert_v     = q.cull ? '0 : q.tv[cnt];
  assign vert_color = q.cull ? '0 : q.col;
  assign corner     = q.cull ? '0 : cnt;
  assign culled     = q.cull;
  assign last       = last_beat;

endmodule

// File: rtl/sprite_quad_clip_vertex_gen.sv
// ----------------------------------------------------------------------------
// sprite_quad_clip_vertex_gen
// turns one sprite into the four corner vertices of its quad, with optional
// clipping against a rectangle and texture re-derivation
// ----------------------------------------------------------------------------
// usage:
//   configuration is written through cfg_we / cfg_index / cfg_data while the
//   block is idle; indexes 0..3 are the clip edges, 4 enables clipping and
//   5 enables vertex colour.
//   a sprite is a transaction on in_valid / in_ready; each vertex is a
//   transaction on out_valid / out_ready, corners in order 0,1,2,3 with last
//   on corner 3. a rejected sprite gives one transaction with culled and last.
//   pipeline: the sprite loads into the input register on the edge that takes
//   it, then passes clip, five divider stages, multiply and sum; its first
//   vertex is offered from the serialiser register. throughput: four vertex
//   transactions per sprite, one per cycle when culled and out_ready is high;
//   the single vertex port sets this, the pipeline itself takes a sprite a cycle.
//   reset clears configuration to zero and empties the pipeline.
//   when out_ready is low the serialiser holds its sprite, the pipeline fills
//   up behind it and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sprite_quad_clip_vertex_gen (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [sqc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sqc_pkg::COORD_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [sqc_pkg::COORD_W-1:0]     pos_x,
  input  logic signed [sqc_pkg::COORD_W-1:0]     pos_y,
  input  logic signed [sqc_pkg::COORD_W-1:0]     depth_z,
  input  logic signed [sqc_pkg::COORD_W-1:0]     width,
  input  logic signed [sqc_pkg::COORD_W-1:0]     height,
  input  logic signed [sqc_pkg::TEX_W-1:0]       tex_origin_u,
  input  logic signed [sqc_pkg::TEX_W-1:0]       tex_origin_v,
  input  logic signed [sqc_pkg::TEX_W-1:0]       tex_xstep_u,
  input  logic signed [sqc_pkg::TEX_W-1:0]       tex_xstep_v,
  input  logic signed [sqc_pkg::TEX_W-1:0]       tex_ystep_u,
  input  logic signed [sqc_pkg::TEX_W-1:0]       tex_ystep_v,
  input  logic [sqc_pkg::COLOR_W-1:0]            sprite_color,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [sqc_pkg::COORD_W-1:0]     vert_x,
  output logic signed [sqc_pkg::COORD_W-1:0]     vert_y,
  output logic signed [sqc_pkg::COORD_W-1:0]     vert_z,
  output logic signed [sqc_pkg::TEX_W-1:0]       vert_u,
  output logic signed [sqc_pkg::TEX_W-1:0]       vert_v,
  output logic [sqc_pkg::COLOR_W-1:0]            vert_color,
  output logic [1:0]                             corner,
  output logic                                   culled,
  output logic                                   last
);
  import sqc_pkg::*;

  // stage numbering: 0 input, 1 clip, 2..6 divider, 7 multiply, 8 sum
  localparam int NST = DIV_STAGES + 4;

  coord_t clip_left;
  coord_t clip_top;
  coord_t clip_right;
  coord_t clip_bottom;
  logic   clip_en;
  logic   color_en;

  logic [NST-1:0] v;
  logic [NST:0]   rdy;
  logic           ser_ready;

  // stage 0
  coord_t a_px, a_py, a_pz, a_w, a_h;
  ext_t   a_ex, a_ey;
  tex_t   a_ou, a_ov, a_xu, a_xv, a_yu, a_yv;
  logic [COLOR_W-1:0] a_col;

  // stage 1
  side_t  b_side_next;
  side_t  b_side;
  ext_t   b_nx0, b_nx1, b_ny0, b_ny1;
  ext_t   nx0_next, nx1_next, ny0_next, ny1_next;
  coord_t b_w, b_h;

  side_t  sb [2:NST-1];
  logic [FRAC_W-1:0] fx0, fx1, fy0, fy1;
  logic [3:0][TEX_W-1:0] tu, tv;
  quad_t  quad;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_right  <= '0;
      clip_bottom <= '0;
      clip_en     <= 1'b0;
      color_en    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIP_LEFT:   clip_left   <= cfg_data;
        REG_CLIP_TOP:    clip_top    <= cfg_data;
        REG_CLIP_RIGHT:  clip_right  <= cfg_data;
        REG_CLIP_BOTTOM: clip_bottom <= cfg_data;
        REG_CLIP_EN:     clip_en     <= cfg_data[0];
        REG_COLOR_EN:    color_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ready ripples back from the serialiser through empty stages
  always_comb begin
    rdy[NST] = ser_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_px  <= pos_x;
      a_py  <= pos_y;
      a_pz  <= depth_z;
      a_w   <= width;
      a_h   <= height;
      a_ex  <= ext_t'(pos_x) + ext_t'(width);
      a_ey  <= ext_t'(pos_y) + ext_t'(height);
      a_ou  <= tex_origin_u;
      a_ov  <= tex_origin_v;
      a_xu  <= tex_xstep_u;
      a_xv  <= tex_xstep_v;
      a_yu  <= tex_ystep_u;
      a_yv  <= tex_ystep_v;
      a_col <= color_en ? sprite_color : '0;
    end
  end

  function automatic ext_t clamp_c(ext_t x, coord_t lo, coord_t hi);
    ext_t t;
    t = (x < ext_t'(hi)) ? x : ext_t'(hi);
    clamp_c = (ext_t'(lo) > t) ? ext_t'(lo) : t;
  endfunction

  always_comb begin
    b_side_next.pz   = a_pz;
    b_side_next.ou   = a_ou;
    b_side_next.ov   = a_ov;
    b_side_next.xu   = a_xu;
    b_side_next.xv   = a_xv;
    b_side_next.yu   = a_yu;
    b_side_next.yv   = a_yv;
    b_side_next.col  = a_col;
    b_side_next.clip = clip_en;
    b_side_next.cull = clip_en && ((a_w <= 0) || (a_h <= 0) ||
                       (a_px >= clip_right) || (a_py >= clip_bottom) ||
                       (a_ex < ext_t'(clip_left)) || (a_ey < ext_t'(clip_top)));
    if (clip_en) begin
      b_side_next.xs0 = clamp_c(ext_t'(a_px), clip_left, clip_right);
      b_side_next.xs1 = clamp_c(a_ex, clip_left, clip_right);
      b_side_next.ys0 = clamp_c(ext_t'(a_py), clip_top, clip_bottom);
      b_side_next.ys1 = clamp_c(a_ey, clip_top, clip_bottom);
    end else begin
      b_side_next.xs0 = ext_t'(a_px);
      b_side_next.xs1 = a_ex;
      b_side_next.ys0 = ext_t'(a_py);
      b_side_next.ys1 = a_ey;
    end
    nx0_next = b_side_next.xs0 - ext_t'(a_px);
    nx1_next = b_side_next.xs1 - ext_t'(a_px);
    ny0_next = b_side_next.ys0 - ext_t'(a_py);
    ny1_next = b_side_next.ys1 - ext_t'(a_py);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b_side <= b_side_next;
      b_nx0  <= nx0_next;
      b_nx1  <= nx1_next;
      b_ny0  <= ny0_next;
      b_ny1  <= ny1_next;
      b_w    <= a_w;
      b_h    <= a_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) sb[2] <= b_side;
    for (int k = 3; k < NST; k++) begin
      if (rdy[k]) sb[k] <= sb[k-1];
    end
  end

  logic [FRAC_W-1:0] dx0, dx1, dy0, dy1;

  sqc_div u_div_x0 (.clk(clk), .en(rdy[DIV_STAGES+1:2]), .num(b_nx0), .den(b_w), .frac(dx0));
  sqc_div u_div_x1 (.clk(clk), .en(rdy[DIV_STAGES+1:2]), .num(b_nx1), .den(b_w), .frac(dx1));
  sqc_div u_div_y0 (.clk(clk), .en(rdy[DIV_STAGES+1:2]), .num(b_ny0), .den(b_h), .frac(dy0));
  sqc_div u_div_y1 (.clk(clk), .en(rdy[DIV_STAGES+1:2]), .num(b_ny1), .den(b_h), .frac(dy1));

  // unclipped sprites use the exact corner fractions
  assign fx0 = sb[DIV_STAGES+1].clip ? dx0 : '0;
  assign fx1 = sb[DIV_STAGES+1].clip ? dx1 : FRAC_ONE;
  assign fy0 = sb[DIV_STAGES+1].clip ? dy0 : '0;
  assign fy1 = sb[DIV_STAGES+1].clip ? dy1 : FRAC_ONE;

  sqc_tex u_tex (
    .clk    (clk),
    .en_mul (rdy[NST-2]),
    .en_sum (rdy[NST-1]),
    .ou     (sb[DIV_STAGES+1].ou),
    .ov     (sb[DIV_STAGES+1].ov),
    .xu     (sb[DIV_STAGES+1].xu),
    .xv     (sb[DIV_STAGES+1].xv),
    .yu     (sb[DIV_STAGES+1].yu),
    .yv     (sb[DIV_STAGES+1].yv),
    .fx0    (fx0),
    .fx1    (fx1),
    .fy0    (fy0),
    .fy1    (fy1),
    .tu     (tu),
    .tv     (tv)
  );

  always_comb begin
    quad.pz   = sb[NST-1].pz;
    quad.xs0  = sb[NST-1].xs0;
    quad.xs1  = sb[NST-1].xs1;
    quad.ys0  = sb[NST-1].ys0;
    quad.ys1  = sb[NST-1].ys1;
    quad.tu   = tu;
    quad.tv   = tv;
    quad.col  = sb[NST-1].col;
    quad.cull = sb[NST-1].cull;
  end

  sqc_out u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v[NST-1]),
    .in_ready   (ser_ready),
    .quad       (quad),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .vert_x     (vert_x),
    .vert_y     (vert_y),
    .vert_z     (vert_z),
    .vert_u     (vert_u),
    .vert_v     (vert_v),
    .vert_color (vert_color),
    .corner     (corner),
    .culled     (culled),
    .last       (last)
  );

endmodule
